/* src/imtk_pkg.sv */
// Shared types and constants for the intra mode top-k selector.
// No dependencies.
`default_nettype none
package imtk_pkg;

    localparam int MODE_W   = 6;
    localparam int DIST_W   = 32;
    localparam int LAMBDA_W = 24;
    localparam int COST_W   = 34;
    localparam int RANK_W   = 4;
    localparam int BITS_W   = 3;
    localparam int PROD_W   = LAMBDA_W + BITS_W;

    localparam logic [BITS_W-1:0] BITS_MPM   = 3'd2;
    localparam logic [BITS_W-1:0] BITS_OTHER = 3'd6;
    localparam logic [COST_W-1:0] COST_EMPTY = {COST_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the accepted transaction
        logic mult;      // form lambda * bits
        logic insert;    // add distortion and insert into the list
        logic emit;      // drive one list slot to the result ports
        logic emit_last; // the slot being driven is the final one
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic end_pending; // captured transaction asked for the list
    } stat_t;

endpackage
`default_nettype wire

/* src/imtk_ctrl.sv */
// Sequencer for the top-k selector: score, insert, then optional list emission.
// Depends on imtk_pkg.
`default_nettype none
module imtk_ctrl #(
    parameter int LIST_SIZE = 8,
    parameter int IDX_W     = 3
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  imtk_pkg::stat_t      stat,
    output imtk_pkg::cmd_t       cmd,
    output logic [IDX_W-1:0]     emit_idx
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCORE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_SIZE - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SCORE;
            end
            ST_SCORE:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cnt_next = '0;
                if (stat.end_pending)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (cnt_reg == LAST_IDX)
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cmd.load      = (state_reg == ST_IDLE) && start;
    assign cmd.mult      = (state_reg == ST_SCORE);
    assign cmd.insert    = (state_reg == ST_INSERT);
    assign cmd.emit      = (state_reg == ST_EMIT);
    assign cmd.emit_last = (cnt_reg == LAST_IDX);
    assign emit_idx      = cnt_reg;

endmodule
`default_nettype wire

/* src/imtk_datapath.sv */
// Datapath: cost calculation, compare-and-shift list and result registers.
// Depends on imtk_pkg.
`default_nettype none
module imtk_datapath #(
    parameter int LIST_SIZE  = 8,
    parameter int MODE_COUNT = 33,
    parameter int IDX_W      = 3
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  imtk_pkg::cmd_t                        cmd,
    input  wire  [IDX_W-1:0]                      emit_idx,
    output imtk_pkg::stat_t                       stat,
    input  wire                                   lambda_we,
    input  wire  [imtk_pkg::LAMBDA_W-1:0]         lambda_wdata,
    input  wire                                   block_start,
    input  wire                                   block_end,
    input  wire  [imtk_pkg::MODE_W-1:0]           mode_id,
    input  wire  [imtk_pkg::DIST_W-1:0]           distortion,
    input  wire  [imtk_pkg::MODE_W-1:0]           mpm_first,
    input  wire  [imtk_pkg::MODE_W-1:0]           mpm_second,
    output logic                                  result_valid,
    output logic [imtk_pkg::RANK_W-1:0]           rank,
    output logic [imtk_pkg::MODE_W-1:0]           best_mode,
    output logic [imtk_pkg::COST_W-1:0]           best_cost,
    output logic                                  end_of_list
);

    localparam int MC_W = imtk_pkg::MODE_W + 1;

    logic [imtk_pkg::LAMBDA_W-1:0] lambda_reg;
    logic [imtk_pkg::MODE_W-1:0]   mode_reg;
    logic [imtk_pkg::DIST_W-1:0]   dist_reg;
    logic [imtk_pkg::MODE_W-1:0]   mpm0_reg, mpm1_reg;
    logic                          end_reg;
    logic [imtk_pkg::PROD_W-1:0]   prod_reg;

    logic [imtk_pkg::MODE_W-1:0]   list_mode_reg [LIST_SIZE];
    logic [imtk_pkg::COST_W-1:0]   list_cost_reg [LIST_SIZE];

    logic                          res_valid_reg;
    logic [imtk_pkg::RANK_W-1:0]   rank_reg;
    logic [imtk_pkg::MODE_W-1:0]   best_mode_reg;
    logic [imtk_pkg::COST_W-1:0]   best_cost_reg;
    logic                          eol_reg;

    logic [imtk_pkg::BITS_W-1:0]   bits;
    logic [imtk_pkg::COST_W:0]     sum;
    logic [imtk_pkg::COST_W-1:0]   cost;
    logic                          mode_ok;
    logic [LIST_SIZE-1:0]          lt;

    assign bits = (mode_reg == mpm0_reg || mode_reg == mpm1_reg) ?
                  imtk_pkg::BITS_MPM : imtk_pkg::BITS_OTHER;
    assign sum  = (imtk_pkg::COST_W+1)'(prod_reg) + (imtk_pkg::COST_W+1)'(dist_reg);
    assign cost = sum[imtk_pkg::COST_W] ? imtk_pkg::COST_EMPTY
                                        : sum[imtk_pkg::COST_W-1:0];
    assign mode_ok = ({1'b0, mode_reg} < MC_W'(MODE_COUNT));

    // list stays sorted, so lt is a run of zeros followed by ones
    always_comb
    begin
        for (int i = 0; i < LIST_SIZE; i++)
            lt[i] = (cost < list_cost_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg    <= '0;
            end_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < LIST_SIZE; i++)
            begin
                list_mode_reg[i] <= '0;
                list_cost_reg[i] <= imtk_pkg::COST_EMPTY;
            end
        end
        else
        begin
            if (lambda_we)
                lambda_reg <= lambda_wdata;
            if (cmd.load)
            begin
                end_reg <= block_end;
                if (block_start)
                begin
                    for (int i = 0; i < LIST_SIZE; i++)
                    begin
                        list_mode_reg[i] <= '0;
                        list_cost_reg[i] <= imtk_pkg::COST_EMPTY;
                    end
                end
            end
            if (cmd.insert && mode_ok)
            begin
                for (int i = 0; i < LIST_SIZE; i++)
                begin
                    if (lt[i])
                    begin
                        if (i == 0)
                        begin
                            list_mode_reg[i] <= mode_reg;
                            list_cost_reg[i] <= cost;
                        end
                        else if (!lt[(i > 0) ? i - 1 : 0])
                        begin
                            list_mode_reg[i] <= mode_reg;
                            list_cost_reg[i] <= cost;
                        end
                        else
                        begin
                            list_mode_reg[i] <= list_mode_reg[(i > 0) ? i - 1 : 0];
                            list_cost_reg[i] <= list_cost_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                end
            end
            res_valid_reg <= cmd.emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_id;
            dist_reg <= distortion;
            mpm0_reg <= mpm_first;
            mpm1_reg <= mpm_second;
        end
        if (cmd.mult)
            prod_reg <= imtk_pkg::PROD_W'(lambda_reg) * imtk_pkg::PROD_W'(bits);
        if (cmd.emit)
        begin
            rank_reg      <= imtk_pkg::RANK_W'(emit_idx);
            best_mode_reg <= list_mode_reg[emit_idx];
            best_cost_reg <= list_cost_reg[emit_idx];
            eol_reg       <= cmd.emit_last;
        end
    end

    assign stat.end_pending = end_reg;
    assign result_valid     = res_valid_reg;
    assign rank             = rank_reg;
    assign best_mode        = best_mode_reg;
    assign best_cost        = best_cost_reg;
    assign end_of_list      = eol_reg;

endmodule
`default_nettype wire

/* src/intra_mode_topk_selector_core.sv */
// Intra mode top-k selector, top level: controller plus datapath.
// Depends on imtk_pkg, imtk_ctrl, imtk_datapath.
// A transaction goes through accept, multiply, insert; busy is high in multiply and insert.
// On block_end the list follows as LIST_SIZE results on consecutive cycles, the first
// registered from the emit state that follows the insert; a new transaction is accepted
// only while busy is low, so not before the insert and any list emission are done.
// Asynchronous active-low reset empties the list and clears lambda; no receiver stall.
`default_nettype none
module intra_mode_topk_selector_core #(
    parameter int LIST_SIZE  = 8,
    parameter int MODE_COUNT = 33
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              lambda_we,
    input  wire  [imtk_pkg::LAMBDA_W-1:0]    lambda_wdata,
    input  wire                              start,
    output logic                             busy,
    input  wire                              block_start,
    input  wire                              block_end,
    input  wire  [imtk_pkg::MODE_W-1:0]      mode_id,
    input  wire  [imtk_pkg::DIST_W-1:0]      distortion,
    input  wire  [imtk_pkg::MODE_W-1:0]      mpm_first,
    input  wire  [imtk_pkg::MODE_W-1:0]      mpm_second,
    output logic                             result_valid,
    output logic [imtk_pkg::RANK_W-1:0]      rank,
    output logic [imtk_pkg::MODE_W-1:0]      best_mode,
    output logic [imtk_pkg::COST_W-1:0]      best_cost,
    output logic                             end_of_list
);

    localparam int IDX_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;

    imtk_pkg::cmd_t   cmd;
    imtk_pkg::stat_t  stat;
    logic [IDX_W-1:0] emit_idx;

    imtk_ctrl #(
        .LIST_SIZE (LIST_SIZE),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .stat     (stat),
        .cmd      (cmd),
        .emit_idx (emit_idx)
    );

    imtk_datapath #(
        .LIST_SIZE  (LIST_SIZE),
        .MODE_COUNT (MODE_COUNT),
        .IDX_W      (IDX_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .emit_idx     (emit_idx),
        .stat         (stat),
        .lambda_we    (lambda_we),
        .lambda_wdata (lambda_wdata),
        .block_start  (block_start),
        .block_end    (block_end),
        .mode_id      (mode_id),
        .distortion   (distortion),
        .mpm_first    (mpm_first),
        .mpm_second   (mpm_second),
        .result_valid (result_valid),
        .rank         (rank),
        .best_mode    (best_mode),
        .best_cost    (best_cost),
        .end_of_list  (end_of_list)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !end_of_list |=> result_valid)
        else $error("gap inside list emission");

    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !end_of_list |=> rank == $past(rank) + 1'b1)
        else $error("rank did not advance by one");

    a_emit_stop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_of_list |=> !result_valid)
        else $error("result after end of list");
`endif

endmodule
`default_nettype wire
